FILE: sv/srps_pkg.sv
package srps_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_END   = 2'd1;
  localparam logic [1:0] REQ_BANK  = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  // Bank select command bytes
  localparam logic [7:0] BANK0_CMD = 8'h0A;
  localparam logic [7:0] BANK1_CMD = 8'h0B;

  // Input word: CPU port write or sample tick
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] write_data;
  } req_t;

  // Result word: one per accepted input word
  typedef struct packed {
    logic        sample_fetch;
    logic [16:0] sample_address;
    logic        playing;
  } rsp_t;

endpackage

FILE: sv/sample_rom_playback_sequencer.sv
// Sample ROM playback sequencer: turns CPU port writes (start page, end page
// and trigger, bank command) and sample-period ticks into 17-bit sample ROM
// fetch addresses. Every accepted word yields exactly one result word in the
// next cycle from the result register; a new word is taken every cycle as
// long as the result register is empty or being drained in the same cycle,
// so sustained throughput is one word per clock. There is no memory and no
// clearing pass; reset puts the sequencer idle at bank 0, pointer 0.
module sample_rom_playback_sequencer
  import srps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_word,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_word
);

  logic [15:0] play_pointer;
  logic [7:0]  start_page;
  logic [7:0]  end_page;
  logic        sample_bank;
  logic        busy;

  logic [15:0] play_pointer_next;
  logic [7:0]  start_page_next;
  logic [7:0]  end_page_next;
  logic        sample_bank_next;
  logic        busy_next;
  rsp_t        rsp_next;

  logic        accept;
  logic        fetch;
  logic [15:0] ptr_base;
  logic [15:0] ptr_inc;

  // Result register frees up when empty or taken this cycle
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Fetch on a trigger from idle, or on a tick while playing
  assign fetch = ((in_word.req_type == REQ_END) && !busy) ||
                 ((in_word.req_type == REQ_TICK) && busy);
  assign ptr_base = (in_word.req_type == REQ_END) ? {start_page, 8'h00} : play_pointer;
  assign ptr_inc  = ptr_base + 16'd1;

  // Next state and result for the word at the input
  always_comb begin
    play_pointer_next = play_pointer;
    start_page_next   = start_page;
    end_page_next     = end_page;
    sample_bank_next  = sample_bank;
    busy_next         = busy;
    case (in_word.req_type)
      REQ_START: begin
        start_page_next = in_word.write_data;
      end
      REQ_END: begin
        end_page_next     = in_word.write_data;
        play_pointer_next = ptr_base;
        busy_next         = 1'b1;
      end
      REQ_BANK: begin
        if (in_word.write_data == BANK0_CMD) begin
          sample_bank_next = 1'b0;
        end else if (in_word.write_data == BANK1_CMD) begin
          sample_bank_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
    // Advance pointer and stop at the end page (new end page on a trigger)
    if (fetch) begin
      play_pointer_next = ptr_inc;
      if (ptr_inc[15:8] == end_page_next) begin
        busy_next = 1'b0;
      end
    end
    rsp_next.sample_fetch   = fetch;
    rsp_next.sample_address = fetch ? {sample_bank, ptr_base} : 17'd0;
    rsp_next.playing        = busy_next;
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      play_pointer <= '0;
      start_page   <= '0;
      end_page     <= '0;
      sample_bank  <= 1'b0;
      busy         <= 1'b0;
    end else if (accept) begin
      play_pointer <= play_pointer_next;
      start_page   <= start_page_next;
      end_page     <= end_page_next;
      sample_bank  <= sample_bank_next;
      busy         <= busy_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word <= rsp_next;
    end
  end

  // A tick while playing always reports a fetch
  assert property (@(posedge clk) disable iff (rst)
    accept && (in_word.req_type == REQ_TICK) && busy |=> out_valid && out_word.sample_fetch)
    else $error("tick while playing gave no fetch");

  // No fetch means a zero address
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.sample_fetch |-> out_word.sample_address == 17'd0)
    else $error("address set without a fetch");

  // Reported playing flag tracks the internal busy flag
  assert property (@(posedge clk) disable iff (rst)
    accept |=> out_word.playing == busy)
    else $error("playing flag out of step with busy");

  // A start page write leaves playback state alone
  assert property (@(posedge clk) disable iff (rst)
    accept && (in_word.req_type == REQ_START) |=>
      busy == $past(busy) && play_pointer == $past(play_pointer))
    else $error("start page write disturbed playback");

  // Bank 1 command selects bank 1
  assert property (@(posedge clk) disable iff (rst)
    accept && (in_word.req_type == REQ_BANK) && (in_word.write_data == BANK1_CMD)
      |=> sample_bank)
    else $error("bank 1 command not taken");

endmodule

FILE: bench/sample_rom_playback_sequencer_tb.sv
module sample_rom_playback_sequencer_tb;
  import srps_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_word;

  // Shadow copy of the playback state
  logic [15:0] pb_pointer = '0;
  logic [7:0]  pb_start_page = '0;
  logic [7:0]  pb_end_page = '0;
  logic        pb_bank = 1'b0;
  logic        pb_busy = 1'b0;

  rsp_t predicted_rsps[$];
  int unsigned played_words = 0;
  int unsigned fault_count = 0;

  // Idle and stall enables, changed per phase
  bit in_idle_on = 1'b0;
  bit out_stall_on = 1'b0;

  sample_rom_playback_sequencer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("sample_rom_playback_sequencer_tb NOT OK");
    $finish;
  end

  // Fetch at the current pointer, step it, stop on reaching the end page
  function automatic logic [16:0] fetch_and_advance();
    logic [16:0] addr;
    addr = {pb_bank, pb_pointer};
    pb_pointer = pb_pointer + 16'd1;
    if (pb_pointer[15:8] == pb_end_page) pb_busy = 1'b0;
    return addr;
  endfunction

  function automatic rsp_t advance_playback(input req_t w);
    rsp_t r;
    logic was_idle;
    r = '0;
    case (w.req_type)
      REQ_START: pb_start_page = w.write_data;
      REQ_END: begin
        was_idle = !pb_busy;
        pb_end_page = w.write_data;
        pb_pointer = {pb_start_page, 8'h00};
        pb_busy = 1'b1;
        if (was_idle) begin
          r.sample_fetch = 1'b1;
          r.sample_address = fetch_and_advance();
        end
      end
      REQ_BANK: begin
        if (w.write_data == BANK0_CMD) pb_bank = 1'b0;
        else if (w.write_data == BANK1_CMD) pb_bank = 1'b1;
      end
      default: begin
        if (pb_busy) begin
          r.sample_fetch = 1'b1;
          r.sample_address = fetch_and_advance();
        end
      end
    endcase
    r.playing = pb_busy;
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Predict accepted words, check returned words
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && in_valid && in_ready) begin
      played_words++;
      predicted_rsps.push_back(advance_playback(in_word));
    end
    if (!rst && out_valid && out_ready) begin
      if (predicted_rsps.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("unexpected result word %h", out_word);
      end else begin
        exp_rsp = predicted_rsps.pop_front();
        if (out_word.sample_fetch !== exp_rsp.sample_fetch ||
            out_word.sample_address !== exp_rsp.sample_address ||
            out_word.playing !== exp_rsp.playing) begin
          fault_count++;
          if (fault_count <= 10)
            $display("mismatch: fetch %b/%b addr %h/%h playing %b/%b (exp/act)",
                     exp_rsp.sample_fetch, out_word.sample_fetch,
                     exp_rsp.sample_address, out_word.sample_address,
                     exp_rsp.playing, out_word.playing);
        end
      end
    end
  end

  // Result side back-pressure
  initial begin
    int unsigned stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = out_stall_on ? gap_len() : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Send one word and hold it until accepted
  task automatic send_word(input logic [1:0] kind, input logic [7:0] data);
    req_t w;
    int unsigned gap;
    w.req_type = kind;
    w.write_data = data;
    gap = in_idle_on ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic test_idle_requests();
    send_word(REQ_TICK, 8'h00);
    send_word(REQ_TICK, 8'hFF);
  endtask

  task automatic test_bank_commands();
    send_word(REQ_BANK, 8'h00);
    send_word(REQ_BANK, 8'hFF);
    send_word(REQ_BANK, BANK1_CMD);
    send_word(REQ_BANK, 8'h0C);
    send_word(REQ_BANK, BANK0_CMD);
  endtask

  // End page equal to start page: one fetch, then idle
  task automatic test_immediate_stop();
    send_word(REQ_START, 8'h12);
    send_word(REQ_END, 8'h12);
    send_word(REQ_TICK, 8'hA5);
  endtask

  task automatic test_idle_trigger();
    send_word(REQ_BANK, BANK1_CMD);
    send_word(REQ_START, 8'hFF);
    send_word(REQ_END, 8'h00);
    send_word(REQ_TICK, 8'h00);
    send_word(REQ_TICK, 8'h5A);
  endtask

  // Retrigger while busy reloads without fetching
  task automatic test_busy_retrigger();
    send_word(REQ_START, 8'h00);
    send_word(REQ_END, 8'hFF);
    send_word(REQ_TICK, 8'h00);
    send_word(REQ_BANK, BANK0_CMD);
    send_word(REQ_TICK, 8'h00);
    send_word(REQ_START, 8'h80);
    send_word(REQ_END, 8'h80);
    send_word(REQ_TICK, 8'h00);
  endtask

  // Whole page from trigger to end page
  task automatic play_page(input logic [7:0] sp, input logic [7:0] ep);
    send_word(REQ_START, sp);
    send_word(REQ_END, ep);
    repeat (258) send_word(REQ_TICK, 8'($urandom));
  endtask

  task automatic test_random_playback();
    logic [7:0] sp;
    logic [7:0] ep;
    in_idle_on = 1'b1;
    out_stall_on = 1'b1;
    // one wrapping page in bank 1, one ordinary page
    send_word(REQ_BANK, BANK1_CMD);
    play_page(8'hFF, 8'h00);
    send_word(REQ_BANK, $urandom_range(0, 1) ? BANK1_CMD : BANK0_CMD);
    sp = 8'($urandom_range(0, 254));
    play_page(sp, sp + 8'd1);
    while (played_words < 1050) begin
      if ($urandom_range(0, 39) == 0) begin
        in_idle_on = 1'($urandom_range(0, 1));
        out_stall_on = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 99) < 70) begin
        if ($urandom_range(0, 2) == 0)
          send_word(REQ_BANK, $urandom_range(0, 1) ? BANK1_CMD : BANK0_CMD);
        sp = 8'($urandom);
        ep = ($urandom_range(0, 2) == 0) ? sp : 8'($urandom);
        send_word(REQ_START, sp);
        send_word(REQ_END, ep);
        repeat ($urandom_range(0, 10)) send_word(REQ_TICK, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) send_word(2'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_requests();
    test_bank_commands();
    test_immediate_stop();
    test_idle_trigger();
    test_busy_retrigger();
    test_random_playback();
    in_valid <= 1'b0;
    while (predicted_rsps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("sample_rom_playback_sequencer_tb OK");
    end else begin
      $display("sample_rom_playback_sequencer_tb NOT OK");
    end
    $finish;
  end

endmodule
